>>> design/bccd_pkg.sv
// Package for the bounded coin-change drawer.
// Holds payload structs, op and status codes, the sequencer state type and
// default sizes. No dependencies.
package bccd_pkg;

    localparam int NUM_SLOTS_DEF  = 6;
    localparam int MAX_AMOUNT_DEF = 1023;
    localparam int MAX_COUNT_DEF  = 255;

    localparam int REG_COUNT = 6;
    localparam int DENOM_W   = 10;
    localparam int AMT_W     = 10;
    localparam int SLOT_W    = 3;
    localparam int LOAD_W    = 8;
    localparam int USED_W    = 8;
    localparam int STAT_W    = 3;
    localparam int TOT_W     = 11;
    localparam int TOT_CAP   = 2047;
    localparam int COINS_W   = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [DENOM_W-1:0] DENOM_RESET [REG_COUNT] =
        '{10'd1, 10'd2, 10'd5, 10'd10, 10'd20, 10'd50};

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_PAY    = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDERPAID = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_CHANGE = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;
    localparam logic [STAT_W-1:0] ST_SATURATED = 3'd5;

    typedef struct packed {
        logic [1:0]         op;
        logic [SLOT_W-1:0]  slot;
        logic [LOAD_W-1:0]  coin_count;
        logic [DENOM_W-1:0] coin_value;
        logic [AMT_W-1:0]   amount;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [DENOM_W-1:0] denom_value;
        logic [USED_W-1:0]  used_count;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic               reached;
        logic [COINS_W-1:0] coins;
        logic [SLOT_W-1:0]  last_slot;
    } tbl_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_NEXT,
        S_RD,
        S_WR,
        S_TR_RD,
        S_TR_CHK,
        S_EMIT,
        S_ONE
    } seq_state_t;

endpackage

>>> design/bounded_coin_change_drawer.sv
// Top level of the bounded coin-change drawer: stock, pending sale and a
// knapsack sequencer over one table memory. Depends on bccd_pkg.
//
//  channel | signals                        | beat
//  in      | in_valid, in_ready, in_data    | one request (load/insert/pay/query)
//  out     | out_valid, out_ready, out_data | one result line
//  cfg     | cfg_we, cfg_index, cfg_data    | one denomination write
//
// Load and insert are answered from the idle state. Query and pay clear the table
// up to A, update it once per stocked coin of value d <= A while stepping the slots,
// trace the chosen coins back from A, then emit one line per used slot or one status line.
// The table needs no clearing after reset; each query or pay clears it up to A.
// The block takes no request while a solve runs; a full output register
// holds the sequencer in the result states.
module bounded_coin_change_drawer
    import bccd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int MAX_AMOUNT = MAX_AMOUNT_DEF,
    parameter int MAX_COUNT  = MAX_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DENOM_W-1:0]   cfg_data
);

    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int SCW       = $clog2(NUM_SLOTS + 1);
    localparam int SIW       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TBL_AMT   = (MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023;
    localparam int TBL_DEPTH = TBL_AMT + 1;
    localparam int TAW       = $clog2(TBL_DEPTH);

    seq_state_t state_reg, state_next;

    logic [DENOM_W-1:0] denom_reg [REG_COUNT];
    logic [DENOM_W-1:0] denom_next [REG_COUNT];
    logic [CNT_W-1:0]   stock_reg [NUM_SLOTS];
    logic [CNT_W-1:0]   stock_next [NUM_SLOTS];
    logic [CNT_W-1:0]   pend_reg [NUM_SLOTS];
    logic [CNT_W-1:0]   pend_next [NUM_SLOTS];
    logic [CNT_W-1:0]   dep_reg [NUM_SLOTS];
    logic [CNT_W-1:0]   dep_next [NUM_SLOTS];
    logic [CNT_W-1:0]   uses_reg [NUM_SLOTS];
    logic [CNT_W-1:0]   uses_next [NUM_SLOTS];
    logic [TOT_W-1:0]   ptotal_reg, ptotal_next;
    logic [AMT_W-1:0]   target_reg, target_next;
    logic [AMT_W-1:0]   v_reg, v_next;
    logic [SCW-1:0]     s_reg, s_next;
    logic [SCW-1:0]     e_reg, e_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               is_pay_reg, is_pay_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    tbl_entry_t         tbl_mem [TBL_DEPTH];
    tbl_entry_t         rd_a_q, rd_b_q, tbl_wd;
    logic [TAW-1:0]     tbl_ra, tbl_rb, tbl_wa;
    logic               tbl_we;

    logic               out_free;
    logic               in_fire;
    logic [DENOM_W-1:0] d_cur;
    logic [DENOM_W-1:0] d_tr;

    function automatic logic [DENOM_W-1:0] slot_value(input logic [SLOT_W-1:0] s);
        logic [DENOM_W-1:0] r;
        r = '0;
        if (32'(s) < NUM_SLOTS && 32'(s) < REG_COUNT)
        begin
            r = denom_reg[s];
        end
        return r;
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        d_cur = slot_value(SLOT_W'(s_reg));
        d_tr  = slot_value(rd_a_q.last_slot);
    end

    // Next state
    always_comb
    begin
        logic fail;
        logic stop;
        logic any_use;
        logic more;
        state_next = state_reg;
        fail    = (v_reg == target_reg) && !rd_a_q.reached;
        stop    = (v_reg == '0) || (d_tr == '0) || (32'(d_tr) > 32'(v_reg));
        any_use = 1'b0;
        more    = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (uses_reg[i] != '0)
            begin
                any_use = 1'b1;
            end
            if (i > 32'(e_reg) && uses_reg[i] != '0)
            begin
                more = 1'b1;
            end
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_data.op == OP_QUERY && 32'(in_data.amount) <= MAX_AMOUNT)
                begin
                    state_next = S_CLR;
                end
                else if (in_fire && in_data.op == OP_PAY && 32'(in_data.amount) <= MAX_AMOUNT
                         && ptotal_reg >= TOT_W'(in_data.amount))
                begin
                    state_next = S_CLR;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (32'(stock_reg[i]) + 32'(pend_reg[i]) > MAX_COUNT)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    if (32'(ptotal_reg - TOT_W'(in_data.amount)) > MAX_AMOUNT)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CLR:
            begin
                if (v_reg == target_reg)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (32'(s_reg) >= NUM_SLOTS)
                begin
                    state_next = S_TR_RD;
                end
                else if (d_cur != '0 && d_cur <= target_reg && k_reg < stock_reg[s_reg[SIW-1:0]])
                begin
                    state_next = S_RD;
                end
            end
            S_RD:     state_next = S_WR;
            S_WR:     state_next = (v_reg == d_cur) ? S_NEXT : S_RD;
            S_TR_RD:  state_next = S_TR_CHK;
            S_TR_CHK:
            begin
                if (fail)
                begin
                    state_next = S_ONE;
                end
                else if (stop)
                begin
                    state_next = any_use ? S_EMIT : S_ONE;
                end
                else
                begin
                    state_next = S_TR_RD;
                end
            end
            S_EMIT:
            begin
                if (out_free && uses_reg[e_reg[SIW-1:0]] != '0 && !more)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        logic found;
        logic ovf;
        logic more;
        logic [TOT_W-1:0] change;
        logic [SIW-1:0]   ls;
        tbl_entry_t       cand;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            denom_next[i] = denom_reg[i];
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            stock_next[i] = stock_reg[i];
            pend_next[i]  = pend_reg[i];
            dep_next[i]   = dep_reg[i];
            uses_next[i]  = uses_reg[i];
        end
        ptotal_next     = ptotal_reg;
        target_next     = target_reg;
        v_next          = v_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        k_next          = k_reg;
        is_pay_next     = is_pay_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        tbl_we          = 1'b0;
        tbl_wa          = TAW'(v_reg);
        tbl_wd          = '0;
        tbl_ra          = TAW'(v_reg);
        tbl_rb          = TAW'(v_reg - AMT_W'(d_cur));
        found           = 1'b0;
        ovf             = 1'b0;
        more            = 1'b0;
        change          = ptotal_reg - TOT_W'(in_data.amount);
        ls              = SIW'(rd_a_q.last_slot);
        cand.reached    = 1'b1;
        cand.coins      = rd_b_q.coins + 1'b1;
        cand.last_slot  = SLOT_W'(s_reg);

        if (cfg_we && 32'(cfg_index) < REG_COUNT)
        begin
            denom_next[cfg_index] = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_next = '{status: ST_OK, denom_value: '0, used_count: '0, last: 1'b1};
                    out_valid_next = 1'b1;
                    case (in_data.op)
                        OP_LOAD:
                        begin
                            if (32'(in_data.slot) >= NUM_SLOTS)
                            begin
                                out_next.status = ST_RANGE;
                            end
                            else if (32'(in_data.coin_count) > MAX_COUNT)
                            begin
                                out_next.status = ST_SATURATED;
                                stock_next[SIW'(in_data.slot)] = CNT_W'(MAX_COUNT);
                            end
                            else
                            begin
                                stock_next[SIW'(in_data.slot)] = CNT_W'(in_data.coin_count);
                            end
                        end
                        OP_INSERT:
                        begin
                            out_next.status = ST_UNKNOWN;
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                if (!found && in_data.coin_value != '0
                                    && slot_value(SLOT_W'(i)) == in_data.coin_value)
                                begin
                                    found = 1'b1;
                                    if (32'(pend_reg[i]) >= MAX_COUNT
                                        || 32'(ptotal_reg) + 32'(in_data.coin_value) > TOT_CAP)
                                    begin
                                        out_next.status = ST_SATURATED;
                                    end
                                    else
                                    begin
                                        out_next.status = ST_OK;
                                        pend_next[i] = pend_reg[i] + 1'b1;
                                        ptotal_next  = ptotal_reg + TOT_W'(in_data.coin_value);
                                    end
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            if (32'(in_data.amount) > MAX_AMOUNT)
                            begin
                                out_next.status = ST_RANGE;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                out_next    = out_reg;
                                target_next = in_data.amount;
                                is_pay_next = 1'b0;
                                v_next      = '0;
                                for (int i = 0; i < NUM_SLOTS; i++)
                                begin
                                    uses_next[i] = '0;
                                end
                            end
                        end
                        default:
                        begin
                            // pay: every outcome drops the pending sale
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                pend_next[i] = '0;
                                if (32'(stock_reg[i]) + 32'(pend_reg[i]) > MAX_COUNT)
                                begin
                                    ovf = 1'b1;
                                end
                            end
                            ptotal_next = '0;
                            if (32'(in_data.amount) > MAX_AMOUNT)
                            begin
                                out_next.status = ST_RANGE;
                            end
                            else if (ptotal_reg < TOT_W'(in_data.amount))
                            begin
                                out_next.status = ST_UNDERPAID;
                            end
                            else if (ovf)
                            begin
                                out_next.status = ST_SATURATED;
                            end
                            else if (32'(change) > MAX_AMOUNT)
                            begin
                                out_next.status = ST_RANGE;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                out_next    = out_reg;
                                target_next = AMT_W'(change);
                                is_pay_next = 1'b1;
                                v_next      = '0;
                                for (int i = 0; i < NUM_SLOTS; i++)
                                begin
                                    stock_next[i] = stock_reg[i] + pend_reg[i];
                                    dep_next[i]   = pend_reg[i];
                                    uses_next[i]  = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                tbl_we         = 1'b1;
                tbl_wd.reached = (v_reg == '0);
                if (v_reg == target_reg)
                begin
                    s_next = '0;
                    k_next = '0;
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            S_NEXT:
            begin
                if (32'(s_reg) >= NUM_SLOTS)
                begin
                    v_next = target_reg;
                end
                else if (d_cur != '0 && d_cur <= target_reg && k_reg < stock_reg[s_reg[SIW-1:0]])
                begin
                    v_next = target_reg;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                    k_next = '0;
                end
            end
            S_WR:
            begin
                // take the coin when v-d is reached and v is unreached or gets strictly fewer coins
                if (rd_b_q.reached && (!rd_a_q.reached || cand.coins < rd_a_q.coins))
                begin
                    tbl_we = 1'b1;
                    tbl_wd = cand;
                end
                if (v_reg == d_cur)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    v_next = v_reg - 1'b1;
                end
            end
            S_TR_CHK:
            begin
                if (v_reg == target_reg && !rd_a_q.reached)
                begin
                    res_status_next = ST_NO_CHANGE;
                    if (is_pay_reg)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            stock_next[i] = stock_reg[i] - dep_reg[i];
                        end
                    end
                end
                else if (v_reg == '0 || d_tr == '0 || 32'(d_tr) > 32'(v_reg))
                begin
                    res_status_next = ST_OK;
                    e_next = '0;
                    if (is_pay_reg)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            stock_next[i] = (uses_reg[i] <= stock_reg[i]) ?
                                            stock_reg[i] - uses_reg[i] : '0;
                        end
                    end
                end
                else
                begin
                    uses_next[ls] = uses_reg[ls] + 1'b1;
                    v_next = v_reg - AMT_W'(d_tr);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (i > 32'(e_reg) && uses_reg[i] != '0)
                        begin
                            more = 1'b1;
                        end
                    end
                    e_next = e_reg + 1'b1;
                    if (uses_reg[e_reg[SIW-1:0]] != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_next.status      = ST_OK;
                        out_next.denom_value = slot_value(SLOT_W'(e_reg));
                        out_next.used_count  = USED_W'(uses_reg[e_reg[SIW-1:0]]);
                        out_next.last        = !more;
                    end
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{status: res_status_reg, denom_value: '0,
                                 used_count: '0, last: 1'b1};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ptotal_reg    <= '0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                denom_reg[i] <= DENOM_RESET[i];
            end
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                stock_reg[i] <= '0;
                pend_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ptotal_reg    <= ptotal_next;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                denom_reg[i] <= denom_next[i];
            end
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                stock_reg[i] <= stock_next[i];
                pend_reg[i]  <= pend_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        v_reg          <= v_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        k_reg          <= k_next;
        is_pay_reg     <= is_pay_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            dep_reg[i]  <= dep_next[i];
            uses_reg[i] <= uses_next[i];
        end
    end

    // Table memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        rd_a_q <= tbl_mem[tbl_ra];
        rd_b_q <= tbl_mem[tbl_rb];
    end

`ifndef SYNTHESIS
    a_tbl_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (state_reg == S_CLR || state_reg == S_WR))
        else $error("table written outside clear or update");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR |-> (d_cur != '0 && v_reg >= d_cur && v_reg <= target_reg))
        else $error("knapsack step outside coin range");

    a_pay_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.op == OP_PAY) |=> ptotal_reg == '0)
        else $error("pending total kept after pay");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while solving");
`endif

endmodule

>>> bench/tb.sv
// Testbench for bounded_coin_change_drawer: directed and random requests against
// an in-bench model of the drawer, with random stalls on both channels.
// Depends on bccd_pkg and the design top level.
module tb
    import bccd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_AMT    = 1023;
    localparam int MAX_CNT    = 255;
    localparam int CYCLE_CAP  = 100000000;
    localparam int DRAIN_WAIT = 50;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DENOM_W-1:0]   cfg_data = '0;

    bounded_coin_change_drawer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // drawer model
    int model_denom [REG_COUNT];
    int model_stock [REG_COUNT];
    int model_pend [REG_COUNT];
    int model_total;
    bit reach_tbl [0:MAX_AMT];
    int coins_tbl [0:MAX_AMT];
    int slot_tbl [0:MAX_AMT];
    int change_uses [REG_COUNT];

    in_item_t  request_q [$];
    out_item_t expected_lines [$];

    int errors = 0;
    int cycles = 0;
    int in_gap;
    int out_gap;
    int hold_left;
    logic hold_kick = 1'b0;
    logic no_idle = 1'b0;

    function void expect_line(logic [STAT_W-1:0] st, int dv, int cnt, bit lst);
        out_item_t line;
        line.status      = st;
        line.denom_value = dv[DENOM_W-1:0];
        line.used_count  = cnt[USED_W-1:0];
        line.last        = lst;
        expected_lines = {expected_lines, line};
    endfunction

    function void queue_request(in_item_t r);
        request_q = {request_q, r};
    endfunction

    // 0/1 knapsack over single coins, slot order, replace only on strictly fewer
    function bit fewest_coins(int amt);
        int v;
        int d;
        int ls;
        for (int s = 0; s < REG_COUNT; s++)
            change_uses[s] = 0;
        for (v = 0; v <= amt; v++)
        begin
            reach_tbl[v] = 1'b0;
            coins_tbl[v] = 0;
            slot_tbl[v]  = 0;
        end
        reach_tbl[0] = 1'b1;
        for (int s = 0; s < REG_COUNT; s++)
        begin
            d = model_denom[s];
            if (d == 0)
                continue;
            for (int k = 0; k < model_stock[s]; k++)
                for (v = amt; v >= d; v--)
                    if (reach_tbl[v-d] &&
                        (!reach_tbl[v] || coins_tbl[v-d] + 1 < coins_tbl[v]))
                    begin
                        reach_tbl[v] = 1'b1;
                        coins_tbl[v] = coins_tbl[v-d] + 1;
                        slot_tbl[v]  = s;
                    end
        end
        if (!reach_tbl[amt])
            return 1'b0;
        v = amt;
        while (v > 0)
        begin
            ls = slot_tbl[v];
            d  = model_denom[ls];
            if (d == 0 || d > v)
                break;
            change_uses[ls]++;
            v -= d;
        end
        return 1'b1;
    endfunction

    function void expect_change();
        int last_s;
        last_s = -1;
        for (int s = 0; s < REG_COUNT; s++)
            if (change_uses[s] != 0)
                last_s = s;
        if (last_s < 0)
            expect_line(ST_OK, 0, 0, 1'b1);
        for (int s = 0; s < REG_COUNT; s++)
            if (change_uses[s] != 0)
                expect_line(ST_OK, model_denom[s], change_uses[s], s == last_s);
    endfunction

    function void clear_sale();
        for (int s = 0; s < REG_COUNT; s++)
            model_pend[s] = 0;
        model_total = 0;
    endfunction

    function void drawer_step(in_item_t r);
        int saved [REG_COUNT];
        int amt;
        int cval;
        int chg;
        logic [STAT_W-1:0] st;
        bit over;
        amt  = r.amount;
        cval = r.coin_value;
        case (r.op)
            OP_LOAD:
            begin
                if (r.slot >= REG_COUNT)
                    expect_line(ST_RANGE, 0, 0, 1'b1);
                else
                begin
                    model_stock[r.slot] = r.coin_count;
                    expect_line(ST_OK, 0, 0, 1'b1);
                end
            end
            OP_INSERT:
            begin
                st = ST_UNKNOWN;
                if (cval != 0)
                    for (int s = 0; s < REG_COUNT; s++)
                        if (model_denom[s] == cval)
                        begin
                            if (model_pend[s] >= MAX_CNT || model_total + cval > TOT_CAP)
                                st = ST_SATURATED;
                            else
                            begin
                                model_pend[s]++;
                                model_total += cval;
                                st = ST_OK;
                            end
                            break;
                        end
                expect_line(st, 0, 0, 1'b1);
            end
            OP_QUERY:
            begin
                if (fewest_coins(amt))
                    expect_change();
                else
                    expect_line(ST_NO_CHANGE, 0, 0, 1'b1);
            end
            default:
            begin
                over = 1'b0;
                for (int s = 0; s < REG_COUNT; s++)
                    if (model_stock[s] + model_pend[s] > MAX_CNT)
                        over = 1'b1;
                chg = model_total - amt;
                if (model_total < amt)
                begin
                    clear_sale();
                    expect_line(ST_UNDERPAID, 0, 0, 1'b1);
                end
                else if (over)
                begin
                    clear_sale();
                    expect_line(ST_SATURATED, 0, 0, 1'b1);
                end
                else if (chg > MAX_AMT)
                begin
                    clear_sale();
                    expect_line(ST_RANGE, 0, 0, 1'b1);
                end
                else
                begin
                    for (int s = 0; s < REG_COUNT; s++)
                    begin
                        saved[s] = model_stock[s];
                        model_stock[s] += model_pend[s];
                    end
                    clear_sale();
                    if (!fewest_coins(chg))
                    begin
                        for (int s = 0; s < REG_COUNT; s++)
                            model_stock[s] = saved[s];
                        expect_line(ST_NO_CHANGE, 0, 0, 1'b1);
                    end
                    else
                    begin
                        for (int s = 0; s < REG_COUNT; s++)
                            model_stock[s] = (change_uses[s] <= model_stock[s]) ?
                                model_stock[s] - change_uses[s] : 0;
                        expect_change();
                    end
                end
            end
        endcase
    endfunction

    function in_item_t mk(logic [1:0] op, int slot, int cnt, int cval, int amt);
        in_item_t r;
        r.op         = op;
        r.slot       = slot[SLOT_W-1:0];
        r.coin_count = cnt[LOAD_W-1:0];
        r.coin_value = cval[DENOM_W-1:0];
        r.amount     = amt[AMT_W-1:0];
        return r;
    endfunction

    // inserts of configured values most often, then loads, pays and queries; small loads keep solves short
    function in_item_t rand_request();
        in_item_t r;
        logic [63:0] raw;
        int pick;
        raw = {$urandom, $urandom};
        r = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            r.op = OP_LOAD;
            r.slot = SLOT_W'($urandom_range(0, 7));
            r.coin_count = LOAD_W'($urandom_range(0, 3));
        end
        else if (pick < 60)
        begin
            r.op = OP_INSERT;
            if ($urandom_range(0, 6) != 0)
                r.coin_value = DENOM_W'(model_denom[$urandom_range(0, REG_COUNT-1)]);
        end
        else if (pick < 80)
        begin
            r.op = OP_PAY;
            r.amount = AMT_W'($urandom_range(0, 300));
        end
        else
        begin
            r.op = OP_QUERY;
            r.amount = AMT_W'($urandom_range(0, 250));
        end
        return r;
    endfunction

    task automatic write_denom(int idx, int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= val[DENOM_W-1:0];
        model_denom[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (request_q.size() != 0 || in_valid || expected_lines.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            queue_request(rand_request());
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                drawer_step(in_data);
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (!no_idle && $urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= $urandom_range(0, 17);
                end
                else if (request_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_kick)
            hold_left <= 600;
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    $error("unexpected result beat %p", out_data);
                    errors++;
                end
                else
                begin
                    out_item_t exp_line;
                    exp_line = expected_lines.pop_front();
                    if (out_data.status !== exp_line.status)
                    begin
                        $error("status: expected %0d got %0d", exp_line.status, out_data.status);
                        errors++;
                    end
                    if (out_data.denom_value !== exp_line.denom_value)
                    begin
                        $error("denom_value: expected %0d got %0d",
                               exp_line.denom_value, out_data.denom_value);
                        errors++;
                    end
                    if (out_data.used_count !== exp_line.used_count)
                    begin
                        $error("used_count: expected %0d got %0d",
                               exp_line.used_count, out_data.used_count);
                        errors++;
                    end
                    if (out_data.last !== exp_line.last)
                    begin
                        $error("last: expected %0d got %0d", exp_line.last, out_data.last);
                        errors++;
                    end
                end
            end
            if (out_gap != 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else if (hold_left != 0)
                out_ready <= 1'b0;
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= $urandom_range(0, 17);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < REG_COUNT; s++)
        begin
            model_denom[s] = DENOM_RESET[s];
            model_stock[s] = 0;
        end
        clear_sale();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset denominations 1,2,5,10,20,50
        queue_request(mk(OP_LOAD, 0, 255, 0, 0));
        queue_request(mk(OP_LOAD, 7, 0, 0, 0));       // bad slot
        queue_request(mk(OP_LOAD, 6, 3, 0, 0));
        queue_request(mk(OP_INSERT, 0, 0, 0, 0));     // zero coin
        queue_request(mk(OP_INSERT, 0, 0, 3, 0));     // unknown coin
        queue_request(mk(OP_INSERT, 0, 0, 1, 0));
        queue_request(mk(OP_PAY, 0, 0, 0, 0));        // deposit overflows slot 0
        queue_request(mk(OP_LOAD, 0, 0, 0, 0));
        queue_request(mk(OP_LOAD, 1, 3, 0, 0));
        queue_request(mk(OP_LOAD, 2, 2, 0, 0));
        queue_request(mk(OP_LOAD, 3, 1, 0, 0));
        queue_request(mk(OP_LOAD, 4, 1, 0, 0));
        queue_request(mk(OP_LOAD, 5, 1, 0, 0));
        queue_request(mk(OP_QUERY, 0, 0, 0, 0));      // zero change
        queue_request(mk(OP_QUERY, 0, 0, 0, 7));
        queue_request(mk(OP_QUERY, 0, 0, 0, 1023));   // no exact change
        queue_request(mk(OP_INSERT, 0, 0, 50, 0));
        queue_request(mk(OP_INSERT, 0, 0, 20, 0));
        queue_request(mk(OP_PAY, 0, 0, 0, 100));      // underpaid
        queue_request(mk(OP_INSERT, 0, 0, 50, 0));
        queue_request(mk(OP_INSERT, 0, 0, 20, 0));
        queue_request(mk(OP_PAY, 0, 0, 0, 63));
        queue_request(mk(OP_INSERT, 0, 0, 10, 0));
        queue_request(mk(OP_PAY, 0, 0, 0, 1));
        wait_drained();

        // fill the block behind a stalled receiver
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        run_random(20);
        wait_drained();

        // extremes: disabled slot and the largest value
        write_denom(0, 0);
        write_denom(1, 3);
        write_denom(2, 7);
        write_denom(3, 100);
        write_denom(4, 511);
        write_denom(5, 1023);
        queue_request(mk(OP_INSERT, 0, 0, 1023, 0));
        queue_request(mk(OP_INSERT, 0, 0, 1023, 0));
        queue_request(mk(OP_INSERT, 0, 0, 1023, 0));  // total would pass the cap
        queue_request(mk(OP_PAY, 0, 0, 0, 0));        // change too large
        queue_request(mk(OP_INSERT, 0, 0, 1, 0));     // slot disabled
        for (int s = 0; s < REG_COUNT; s++)
            queue_request(mk(OP_LOAD, s, 2, 0, 0));
        run_random(25);
        wait_drained();

        write_denom(0, 1);
        write_denom(1, 4);
        write_denom(2, 9);
        write_denom(3, 25);
        write_denom(4, 60);
        write_denom(5, 200);
        run_random(10);
        wait_drained();
        no_idle <= 1'b1;
        run_random(10);
        wait_drained();

        if (errors == 0 && expected_lines.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
